FILE: rtl/core/hps_pkg.sv
// Shared types, constants and tables for the Hall position PID servo.
`default_nettype none
package hps_pkg;

  localparam int GAIN_W = 32;
  localparam int CNT_W  = $clog2(GAIN_W);
  localparam int CFG_W  = 32;
  localparam int IDX_W  = 4;
  localparam int FRAC_W = 24;

  localparam logic [63:0] PROD_LIM  = 64'd1 << 61;
  localparam logic [63:0] DUTY_KNEE = (64'd9900 << FRAC_W) / 64'd255;
  localparam logic [12:0] DIV100_MUL = 13'd5243;
  localparam int          DIV100_SH  = 19;

  localparam logic signed [31:0] SUM_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] SUM_MIN = 32'sh8000_0000;

  localparam logic [5:0] PAT_CLAMP = 6'h3F;
  localparam logic [5:0] PAT_HOLD  = 6'h07;
  localparam logic [7:0] DUTY_FULL = 8'd255;

  localparam logic [5:0] DRIVE_TBL [2][8] = '{
    '{6'h07, 6'h26, 6'h0D, 6'h25, 6'h13, 6'h16, 6'h0B, 6'h3F},
    '{6'h07, 6'h0B, 6'h16, 6'h13, 6'h25, 6'h0D, 6'h26, 6'h3F}
  };

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_HALL = 2'd1,
    CMD_GOAL = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [IDX_W-1:0] {
    CFG_KP       = 4'd0,
    CFG_KI       = 4'd1,
    CFG_KD       = 4'd2,
    CFG_STEP     = 4'd3,
    CFG_START    = 4'd4,
    CFG_DEADBAND = 4'd5,
    CFG_BASE     = 4'd6,
    CFG_INTEG    = 4'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SETP, S_ERR, S_MST, S_MUL, S_SUM1, S_SUM2, S_CMD, S_SCALE, S_DIV, S_EMIT
  } state_t;

  typedef struct packed {
    logic start;
  } mul_ctl_t;

  typedef struct packed {
    logic done;
  } mul_sts_t;

endpackage
`default_nettype wire

FILE: rtl/core/hps_smul.sv
// Bit-serial saturating multiplier: unsigned gain by signed operand, one gain bit a cycle.
`default_nettype none
module hps_smul #(
  parameter int MW = 32
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire hps_pkg::mul_ctl_t     ctl,
  input  wire  [hps_pkg::GAIN_W-1:0] gain,
  input  wire  signed [MW:0]         x,
  output hps_pkg::mul_sts_t          sts,
  output logic signed [63:0]         product
);

  localparam int PW = hps_pkg::GAIN_W + MW;

  logic                        run;
  logic                        fin;
  logic                        done;
  logic [hps_pkg::CNT_W-1:0]   cnt;
  logic [hps_pkg::GAIN_W-1:0]  g;
  logic [MW-1:0]               mag;
  logic                        neg;
  logic [MW-1:0]               hi;
  logic [hps_pkg::GAIN_W-1:0]  lo;
  logic [MW:0]                 t;
  logic [MW:0]                 x_abs;
  logic [PW-1:0]               prod;
  logic [63:0]                 sat;

  always_comb begin
    x_abs = x[MW] ? (MW+1)'(-x) : x;
    t     = {1'b0, hi} + (g[0] ? {1'b0, mag} : '0);
    prod  = {hi, lo};
    sat   = (prod > PW'(hps_pkg::PROD_LIM)) ? hps_pkg::PROD_LIM : prod[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        run <= 1'b1;
        cnt <= '0;
        g   <= gain;
        mag <= x_abs[MW-1:0];
        neg <= x[MW];
        hi  <= '0;
        lo  <= '0;
      end else if (run) begin
        hi  <= t[MW:1];
        lo  <= {t[0], lo[hps_pkg::GAIN_W-1:1]};
        g   <= g >> 1;
        cnt <= cnt + 1'b1;
        if (cnt == '1) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end else if (fin) begin
        fin     <= 1'b0;
        done    <= 1'b1;
        product <= neg ? -$signed(sat) : $signed(sat);
      end
    end
  end

  assign sts.done = done;

endmodule
`default_nettype wire

FILE: rtl/core/hall_position_pid_servo_top.sv
// Top level of the Hall position PID servo: registers, sequencer and datapath.
//
//  channel | signals                                   | role
//  in      | in_valid, in_stall, command..retract      | ticks, Hall edges, goal loads
//  out     | out_valid, out_stall, phase_pattern..     | drive pattern, duty, direction
//  cfg     | cfg_write, cfg_index, cfg_data            | register writes, no read-back
//
// A control tick steps through setpoint, error, multiply, summing, command and emit,
// with scale and divide steps before emit when the output clears the deadband; in the
// multiply step the three bit-serial multipliers work side by side, one gain bit a cycle.
// A Hall edge while running goes straight to emit; other transactions finish in idle.
// Synchronous reset sets settings, control state and out_valid; no clearing pass.
// in_stall is high while a transaction is in work; a result waits in the
// output register while out_stall is high, and the next input is still taken.
`default_nettype none
module hall_position_pid_servo_top #(
  parameter int POS_WIDTH = 16
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire  [1:0]                      command,
  input  wire  [2:0]                      hall_code,
  input  wire  signed [15:0]              goal_value,
  input  wire                             retract,
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic [5:0]                      phase_pattern,
  output logic [7:0]                      duty,
  output logic                            direction,
  output logic                            clamped,
  input  wire                             cfg_write,
  input  wire  [hps_pkg::IDX_W-1:0]       cfg_index,
  input  wire  [hps_pkg::CFG_W-1:0]       cfg_data
);

  localparam int P     = POS_WIDTH;
  localparam int MW    = (P + 2 > 32) ? P + 2 : 32;
  localparam int SUM_W = ((P + 1 > 32) ? P + 1 : 32) + 1;

  hps_pkg::state_t state, state_next;

  logic [31:0]        kp_gain, ki_gain, kd_gain;
  logic [7:0]         follow_step, deadband, base_duty;

  logic signed [P-1:0] position, setpoint, target;
  logic signed [P:0]   last_error, e_r;
  logic signed [P+1:0] d_r;
  logic signed [31:0]  error_sum;
  logic                retract_pending, run_mode, turn_dir;
  logic [7:0]          duty_reg;
  logic [2:0]          hall_r;
  logic signed [63:0]  acc;
  logic [63:0]         mag;
  logic                over;
  logic [13:0]         y_r;

  hps_pkg::mul_ctl_t  mctl;
  hps_pkg::mul_sts_t  msts0, msts1, msts2;
  logic signed [63:0] prod0, prod1, prod2;

  logic               accept, out_free;
  logic signed [47:0] cfg_ext, goal_ext;
  logic signed [P:0]  sp_x, tg_x, step_x, sp_up, sp_dn, e_c;
  logic signed [SUM_W-1:0] sum_c;
  logic signed [63:0] db_pos, db_neg;
  logic [37:0]        m255;
  logic [26:0]        q_c;
  logic [5:0]         pat_c;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != hps_pkg::S_IDLE);

  always_comb begin
    cfg_ext  = 48'(signed'(cfg_data[15:0]));
    goal_ext = 48'(goal_value);
    sp_x     = (P+1)'(setpoint);
    tg_x     = (P+1)'(target);
    step_x   = $signed({{(P-7){1'b0}}, follow_step});
    sp_up    = sp_x + step_x;
    sp_dn    = sp_x - step_x;
    e_c      = sp_x - (P+1)'(position);
    sum_c    = SUM_W'(error_sum) + SUM_W'(e_c);
    db_pos   = $signed({32'd0, deadband, 24'd0});
    db_neg   = -db_pos;
    m255     = 38'(mag[29:0]) * 38'd255;
    q_c      = 27'(y_r) * 27'(hps_pkg::DIV100_MUL);
    if (!run_mode) begin
      pat_c = hps_pkg::PAT_CLAMP;
    end else if (duty_reg == 8'd0) begin
      pat_c = hps_pkg::PAT_HOLD;
    end else begin
      pat_c = hps_pkg::DRIVE_TBL[turn_dir][hall_r];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hps_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mctl.start = 1'b0;
    unique case (state)
      hps_pkg::S_IDLE: begin
        if (accept) begin
          if (command == hps_pkg::CMD_TICK) begin
            state_next = hps_pkg::S_SETP;
          end else if (command == hps_pkg::CMD_HALL && run_mode) begin
            state_next = hps_pkg::S_EMIT;
          end
        end
      end
      hps_pkg::S_SETP:  state_next = hps_pkg::S_ERR;
      hps_pkg::S_ERR:   state_next = hps_pkg::S_MST;
      hps_pkg::S_MST: begin
        mctl.start = 1'b1;
        state_next = hps_pkg::S_MUL;
      end
      hps_pkg::S_MUL: begin
        if (msts0.done) begin
          state_next = hps_pkg::S_SUM1;
        end
      end
      hps_pkg::S_SUM1:  state_next = hps_pkg::S_SUM2;
      hps_pkg::S_SUM2:  state_next = hps_pkg::S_CMD;
      hps_pkg::S_CMD: begin
        state_next = (acc <= db_neg || acc >= db_pos) ? hps_pkg::S_SCALE : hps_pkg::S_EMIT;
      end
      hps_pkg::S_SCALE: state_next = hps_pkg::S_DIV;
      hps_pkg::S_DIV:   state_next = hps_pkg::S_EMIT;
      hps_pkg::S_EMIT: begin
        if (out_free) begin
          state_next = hps_pkg::S_IDLE;
        end
      end
      default: state_next = hps_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain         <= 32'd45298483;
      ki_gain         <= 32'd151;
      kd_gain         <= 32'd16777216;
      follow_step     <= 8'd2;
      deadband        <= 8'd3;
      base_duty       <= 8'd0;
      position        <= '0;
      setpoint        <= '0;
      target          <= '0;
      last_error      <= '0;
      error_sum       <= '0;
      retract_pending <= 1'b0;
      run_mode        <= 1'b0;
      turn_dir        <= 1'b0;
      duty_reg        <= 8'd0;
      out_valid       <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != hps_pkg::S_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        hps_pkg::S_IDLE: begin
          if (accept) begin
            hall_r <= hall_code;
            if (command == hps_pkg::CMD_HALL) begin
              position <= turn_dir ? position - 1'b1 : position + 1'b1;
            end else if (command == hps_pkg::CMD_GOAL) begin
              target          <= goal_ext[P-1:0];
              retract_pending <= retract;
            end
          end
        end
        hps_pkg::S_SETP: begin
          if (target > setpoint) begin
            setpoint <= (tg_x < sp_up) ? target : sp_up[P-1:0];
          end else if (target < setpoint) begin
            setpoint <= (tg_x > sp_dn) ? target : sp_dn[P-1:0];
          end else if (retract_pending) begin
            retract_pending <= 1'b0;
            target          <= '0;
          end else begin
            run_mode <= 1'b0;
          end
        end
        hps_pkg::S_ERR: begin
          e_r        <= e_c;
          d_r        <= (P+2)'(e_c) - (P+2)'(last_error);
          last_error <= e_c;
          if (sum_c > SUM_W'(hps_pkg::SUM_MAX)) begin
            error_sum <= hps_pkg::SUM_MAX;
          end else if (sum_c < SUM_W'(hps_pkg::SUM_MIN)) begin
            error_sum <= hps_pkg::SUM_MIN;
          end else begin
            error_sum <= sum_c[31:0];
          end
        end
        hps_pkg::S_SUM1: acc <= prod0 + prod1;
        hps_pkg::S_SUM2: acc <= acc + prod2;
        hps_pkg::S_CMD: begin
          mag <= acc[63] ? 64'(-acc) : acc;
          if (acc <= db_neg) begin
            run_mode <= 1'b1;
            turn_dir <= 1'b1;
          end else if (acc >= db_pos) begin
            run_mode <= 1'b1;
            turn_dir <= 1'b0;
          end else begin
            duty_reg <= 8'd0;
          end
        end
        hps_pkg::S_SCALE: begin
          over <= (mag > hps_pkg::DUTY_KNEE);
          y_r  <= m255[37:hps_pkg::FRAC_W];
        end
        hps_pkg::S_DIV: begin
          duty_reg <= over ? hps_pkg::DUTY_FULL
                           : q_c[hps_pkg::DIV100_SH +: 8];
        end
        hps_pkg::S_EMIT: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            phase_pattern <= pat_c;
            duty          <= run_mode ? duty_reg : base_duty;
            direction     <= turn_dir;
            clamped       <= !run_mode;
            if (!run_mode) begin
              duty_reg <= base_duty;
            end
          end
        end
        default: ;
      endcase
      if (cfg_write) begin
        unique case (cfg_index)
          hps_pkg::CFG_KP:       kp_gain     <= cfg_data;
          hps_pkg::CFG_KI:       ki_gain     <= cfg_data;
          hps_pkg::CFG_KD:       kd_gain     <= cfg_data;
          hps_pkg::CFG_STEP:     follow_step <= cfg_data[7:0];
          hps_pkg::CFG_START: begin
            position       <= cfg_ext[P-1:0];
            setpoint       <= cfg_ext[P-1:0];
            last_error     <= (P+1)'(signed'(cfg_ext[P-1:0]));
          end
          hps_pkg::CFG_DEADBAND: deadband    <= cfg_data[7:0];
          hps_pkg::CFG_BASE:     base_duty   <= cfg_data[7:0];
          hps_pkg::CFG_INTEG:    error_sum   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  hps_smul #(.MW(MW)) u_mul_p (
    .clk(clk), .rst(rst), .ctl(mctl), .gain(kp_gain),
    .x((MW+1)'(e_r)), .sts(msts0), .product(prod0)
  );

  hps_smul #(.MW(MW)) u_mul_i (
    .clk(clk), .rst(rst), .ctl(mctl), .gain(ki_gain),
    .x((MW+1)'(error_sum)), .sts(msts1), .product(prod1)
  );

  hps_smul #(.MW(MW)) u_mul_d (
    .clk(clk), .rst(rst), .ctl(mctl), .gain(kd_gain),
    .x((MW+1)'(d_r)), .sts(msts2), .product(prod2)
  );

  a_rise_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == hps_pkg::S_EMIT))
    else $error("result appeared outside the emit step");

  a_clamp_pattern: assert property (@(posedge clk) disable iff (rst)
    (out_valid && clamped) |-> (phase_pattern == hps_pkg::PAT_CLAMP))
    else $error("clamped result without the clamp pattern");

  a_mul_lockstep: assert property (@(posedge clk) disable iff (rst)
    msts0.done |-> (msts1.done && msts2.done && state == hps_pkg::S_MUL))
    else $error("multipliers out of step with the sequencer");

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state == hps_pkg::S_MUL) |-> in_stall)
    else $error("input taken during a PID step");

endmodule
`default_nettype wire
